// File: design/mbps_pkg.sv
// Package: shared types and constants for the masked byte pattern search unit.
package mbps_pkg;

   localparam int MAX_PATTERN_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int LEN_W = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int OFFSET_W = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CARE_MASK = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd3;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] care_mask;
      logic [LEN_W-1:0] pattern_length;
   } cfg_type;

   typedef struct packed {
      logic found;
      logic [OFFSET_W-1:0] match_offset;
   } result_type;

endpackage

// File: design/mbps_if.sv
// Interfaces: request, response and register-write channels.
interface mbps_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic region_end;
   modport source(output valid, output data_byte, output region_end, input ready);
   modport sink(input valid, input data_byte, input region_end, output ready);
endinterface

interface mbps_rsp_if;
   import mbps_pkg::*;
   logic valid;
   logic ready;
   logic found;
   logic [OFFSET_W-1:0] match_offset;
   modport source(output valid, output found, output match_offset, input ready);
   modport sink(input valid, input found, input match_offset, output ready);
endinterface

interface mbps_csr_if;
   import mbps_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [63:0] wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

// File: design/mbps_front.sv
// Front end: byte window, region byte count and per-byte match classification.
module mbps_front #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 region_end,
   input  mbps_pkg::cfg_type    cfg,
   output logic                 push,
   output mbps_pkg::result_type push_data
);
   import mbps_pkg::*;

   logic [7:0]          window_ff [MAX_PATTERN];
   logic [7:0]          window_in [MAX_PATTERN];
   logic [OFFSET_W-1:0] count_ff;
   logic [OFFSET_W-1:0] count_in;
   logic                seen_ff;
   logic                seen_in;

   logic [LEN_W-1:0]    len_use;
   logic [OFFSET_W-1:0] count_next;
   logic                hit;
   logic                match_now;
   logic [127:0]        sig_bytes;

   always_comb begin
      logic [7:0] sel;
      sel = '0;
      // effective length: zero means one, clamp to window depth
      if (cfg.pattern_length == '0) begin
         len_use = LEN_W'(1);
      end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
         len_use = LEN_W'(MAX_PATTERN);
      end else begin
         len_use = cfg.pattern_length;
      end

      window_in[0] = data_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end

      sig_bytes = {cfg.pattern_high, cfg.pattern_low};

      // signature byte k lines up with window slot len-1-k
      hit = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         sel = '0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) == len_use - LEN_W'(1) - LEN_W'(k)) begin
               sel = window_in[j];
            end
         end
         if ((LEN_W'(k) < len_use) && cfg.care_mask[k] && (sel != sig_bytes[8*k +: 8])) begin
            hit = 1'b0;
         end
      end

      count_next = (count_ff == '1) ? count_ff : count_ff + OFFSET_W'(1);
      match_now = !seen_ff && (count_next >= OFFSET_W'(len_use)) && hit;

      push = accept && (match_now || (region_end && !seen_ff));
      push_data.found = match_now;
      push_data.match_offset = match_now ? count_next - OFFSET_W'(len_use) : '0;

      seen_in = region_end ? 1'b0 : (seen_ff | match_now);
      count_in = region_end ? '0 : count_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         seen_ff <= seen_in;
      end
   end

   // window contents are only compared once the count covers the length
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

endmodule

// File: design/mbps_queue.sv
// Short result queue between front end and output stage.
module mbps_queue #(
   parameter int DEPTH = mbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbps_pkg::result_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 nonempty,
   output mbps_pkg::result_type head
);
   import mbps_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   always_comb begin
      full = (count_ff == CNT_W'(DEPTH));
      nonempty = (count_ff != '0);
      head = entries_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop = pop && nonempty;

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: design/mbps_back.sv
// Output stage: response register fed from the result queue.
module mbps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_nonempty,
   input  mbps_pkg::result_type q_head,
   output logic                 q_pop,
   input  logic                 out_ready,
   output logic                 out_valid,
   output mbps_pkg::result_type out_data
);
   import mbps_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   always_comb begin
      q_pop = q_nonempty && (!valid_ff || out_ready);
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      out_valid = valid_ff;
      out_data = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= q_head;
      end
   end

endmodule

// File: design/masked_byte_pattern_search_unit.sv
// Top level: masked byte pattern search unit with register bank and channels.
//
//   channel    dir   transaction                     payload
//   req_chan   in    one byte of the scanned region  data_byte[7:0], region_end
//   rsp_chan   out   one search result               found, match_offset[31:0]
//   csr_chan   in    one register write              index[1:0], wdata[63:0]
//
// Throughput is one byte per cycle while the result queue is not full: the
// front end shifts the byte window and compares all signature positions in
// parallel in the accept cycle. A result passes from the front end into the
// queue and from the queue into the output register before it reaches rsp_chan.
// Synchronous active-high reset clears counts, queue and output valid, and
// loads the register defaults (care mask all ones, length one).
// req_chan.ready drops only when the result queue is full, which happens
// only after rsp_chan has been stalled; csr_chan is always ready.
module masked_byte_pattern_search_unit #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEFAULT,
   parameter int QUEUE_DEPTH = mbps_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   mbps_req_if.sink     req_chan,
   mbps_rsp_if.source   rsp_chan,
   mbps_csr_if.sink     csr_chan
);
   import mbps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       req_accept;
   logic       push;
   result_type push_data;
   logic       q_full;
   logic       q_nonempty;
   result_type q_head;
   logic       q_pop;
   result_type out_data;

   // register bank; a write applies from the next byte transaction on
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_PATTERN_LOW:    cfg_in.pattern_low = csr_chan.wdata;
            REG_PATTERN_HIGH:   cfg_in.pattern_high = csr_chan.wdata;
            REG_CARE_MASK:      cfg_in.care_mask = csr_chan.wdata[15:0];
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_chan.wdata[LEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low <= '0;
         cfg_ff.pattern_high <= '0;
         cfg_ff.care_mask <= '1;
         cfg_ff.pattern_length <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !q_full;
   assign req_accept = req_chan.valid && !q_full;

   mbps_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_chan.data_byte),
      .region_end (req_chan.region_end),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data)
   );

   mbps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (q_pop),
      .full      (q_full),
      .nonempty  (q_nonempty),
      .head      (q_head)
   );

   mbps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .out_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_data   (out_data)
   );

   assign rsp_chan.found = out_data.found;
   assign rsp_chan.match_offset = out_data.match_offset;

endmodule

// File: design/mbps_checker.sv
// Checker: port-level assertions for the search unit, bound to the top level.
module mbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_match_offset,
   input logic        csr_ready
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_match_offset))
      else $error("response changed while stalled");

   // a not-found result carries a zero offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == 32'd0)
      else $error("not-found result with nonzero offset");

   // nothing is pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response or backpressure right after reset");

   // input only backs up while a response is pending after an output stall
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && $past(rsp_valid && !rsp_ready))
      else $error("input stalled without output backpressure");

   // register port never stalls
   assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port not ready");

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_found        (rsp_chan.found),
   .rsp_match_offset (rsp_chan.match_offset),
   .csr_ready        (csr_chan.ready)
);
